>>> sv/keyed_decimal_field_extractor_macros.svh
// ---------------------------------------------------------------------------
// Keyed decimal field extractor assertion macros
// Shared concurrent assertion forms, clocked and disabled by a low reset.
// ---------------------------------------------------------------------------
`ifndef KEYED_DECIMAL_FIELD_EXTRACTOR_MACROS_SVH
`define KEYED_DECIMAL_FIELD_EXTRACTOR_MACROS_SVH

// same-cycle implication
`define KDFE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kdfe check failed");

// next-cycle implication
`define KDFE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kdfe check failed");

`endif

>>> sv/kdfe_pkg.sv
// ---------------------------------------------------------------------------
// Keyed decimal field extractor package
// Character codes, status and register codes, and shared payload types.
// ---------------------------------------------------------------------------
`default_nettype none

package kdfe_pkg;

    localparam logic [7:0] CHAR_EQ    = 8'h3D;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [3:0] RADIX      = 4'd10;

    localparam logic [30:0] ACC_MAX = 31'h7FFF_FFFF;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_NO_NUL   = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_LENGTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_CHARS  = 2'd1;

    localparam logic [2:0]  KEY_LENGTH_RESET = 3'd2;
    localparam logic [31:0] KEY_CHARS_RESET  = 32'h0000_4443;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       last_byte;
    } t_byte_item;

    typedef struct packed {
        logic [1:0]         status;
        logic               found;
        logic signed [31:0] value;
    } t_result;

    // key character k; positions past the 32-bit word read as zero
    function automatic logic [7:0] key_byte(input logic [31:0] chars, input int k);
        key_byte = 8'(chars >> (8 * k));
    endfunction

endpackage

`default_nettype wire

>>> sv/kdfe_ifs.sv
// ---------------------------------------------------------------------------
// Keyed decimal field extractor interfaces
// Text input, result output and register write channels.
// ---------------------------------------------------------------------------
`default_nettype none

interface kdfe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       last_byte;

    modport source (output valid, text_byte, last_byte, input ready);
    modport sink   (input valid, text_byte, last_byte, output ready);
endinterface

interface kdfe_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic               found;
    logic signed [31:0] value;

    modport source (output valid, status, found, value, input ready);
    modport sink   (input valid, status, found, value, output ready);
endinterface

interface kdfe_cfg_if;
    import kdfe_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [31:0]            data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> sv/keyed_decimal_field_extractor.sv
// ---------------------------------------------------------------------------
// Keyed decimal field extractor
// Searches a byte stream for a configured key and returns the signed decimal
// value that follows its last occurrence before the first NUL.
//
//   channel   dir   payload                          result per transaction
//   i_text    in    text_byte[7:0], last_byte        one byte of text
//   i_cfg     in    index[1:0], data[31:0]           register write
//   o_result  out   status[1:0], found, value[31:0]  one per last_byte
//
// One byte a cycle unless a last_byte waits: input register, then window
// compare and x10 accumulate into the text state; the result register loads
// on that same edge, as the core takes the last_byte from the input register.
// A last_byte transaction waits in the input register while an earlier
// result is still untaken; other bytes pass regardless.
// Synchronous reset clears the text state and loads the register defaults.
// ---------------------------------------------------------------------------
`default_nettype none

module keyed_decimal_field_extractor #(
    parameter int MAX_KEY_LENGTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    kdfe_in_if.sink      i_text,
    kdfe_cfg_if.sink     i_cfg,
    kdfe_out_if.source   o_result
);
    import kdfe_pkg::*;

    logic [2:0]  r_key_length, n_key_length;
    logic [31:0] r_key_chars, n_key_chars;

    t_byte_item  in_item;
    t_byte_item  st_item;
    logic        st_valid;
    logic        take;
    t_result     res;
    logic        res_valid;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_key_length = r_key_length;
        n_key_chars  = r_key_chars;
        if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_KEY_LENGTH: n_key_length = i_cfg.data[2:0];
                REG_KEY_CHARS:  n_key_chars  = i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_length <= KEY_LENGTH_RESET;
            r_key_chars  <= KEY_CHARS_RESET;
        end else begin
            r_key_length <= n_key_length;
            r_key_chars  <= n_key_chars;
        end
    end

    assign in_item.text_byte = i_text.text_byte;
    assign in_item.last_byte = i_text.last_byte;

    kdfe_in_stage u_in_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_text.valid),
        .o_ready      (i_text.ready),
        .i_item       (in_item),
        .o_item_valid (st_valid),
        .o_item       (st_item),
        .i_take       (take)
    );

    kdfe_core #(
        .MAX_KEY_LENGTH (MAX_KEY_LENGTH)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (st_valid),
        .i_item       (st_item),
        .o_take       (take),
        .i_key_length (r_key_length),
        .i_key_chars  (r_key_chars),
        .o_res_valid  (res_valid),
        .o_res        (res),
        .i_res_ready  (o_result.ready)
    );

    assign o_result.valid  = res_valid;
    assign o_result.status = res.status;
    assign o_result.found  = res.found;
    assign o_result.value  = res.value;

endmodule

`default_nettype wire

>>> sv/kdfe_in_stage.sv
// ---------------------------------------------------------------------------
// Keyed decimal field extractor input register
// Holds one text byte transaction until the parser core takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module kdfe_in_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  kdfe_pkg::t_byte_item i_item,
    output logic                o_item_valid,
    output kdfe_pkg::t_byte_item o_item,
    input  logic                i_take
);
    import kdfe_pkg::*;

    logic       r_valid;
    logic       n_valid;
    t_byte_item r_item;

    assign o_ready      = !r_valid || i_take;
    assign o_item_valid = r_valid;
    assign o_item       = r_item;

    always_comb begin
        n_valid = r_valid;
        if (o_ready) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

>>> sv/kdfe_core.sv
// ---------------------------------------------------------------------------
// Keyed decimal field extractor parser core
// Key window compare, field parse and decimal accumulate, with the result
// register; one byte a cycle unless a last_byte waits on an untaken result.
// ---------------------------------------------------------------------------
`default_nettype none

`include "keyed_decimal_field_extractor_macros.svh"

module kdfe_core #(
    parameter int MAX_KEY_LENGTH = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_item_valid,
    input  kdfe_pkg::t_byte_item i_item,
    output logic                 o_take,
    input  logic [2:0]           i_key_length,
    input  logic [31:0]          i_key_chars,
    output logic                 o_res_valid,
    output kdfe_pkg::t_result    o_res,
    input  logic                 i_res_ready
);
    import kdfe_pkg::*;

    localparam int CW = $clog2(MAX_KEY_LENGTH + 1);
    localparam logic [CW-1:0] MAX_LEN = CW'(MAX_KEY_LENGTH);
    localparam logic [3:0]    MAX_LEN4 = 4'(MAX_KEY_LENGTH);

    typedef enum logic [1:0] {
        PH_SEARCH,
        PH_AFTER_KEY,
        PH_AFTER_EQ,
        PH_DIGITS
    } t_phase;

    logic [MAX_KEY_LENGTH-1:0][7:0] r_recent, n_recent;
    logic [CW-1:0]                  r_bsc, n_bsc;
    t_phase                         r_phase, n_phase;
    logic                           r_neg, n_neg;
    logic [30:0]                    r_acc, n_acc;
    logic                           r_found, n_found;
    logic                           r_term, n_term;
    logic                           r_over, n_over;
    logic                           r_out_valid, n_out_valid;
    t_result                        r_res, n_res;

    logic [MAX_KEY_LENGTH-1:0][7:0] win;
    logic [CW-1:0]                  eff_len;
    logic                           hit;
    logic                           ok;
    logic [7:0]                     b;
    logic                           is_digit;
    logic [3:0]                     digit;
    logic [34:0]                    prod;
    logic                           consumed;
    logic                           take;
    logic                           res_now;

    assign b        = i_item.text_byte;
    assign take     = i_item_valid && (!i_item.last_byte || !r_out_valid || i_res_ready);
    assign res_now  = take && i_item.last_byte;
    assign o_take   = take;
    assign o_res_valid = r_out_valid;
    assign o_res    = r_res;

    always_comb begin
        if (i_key_length == 3'd0) begin
            eff_len = CW'(1);
        end else if ({1'b0, i_key_length} > MAX_LEN4) begin
            eff_len = MAX_LEN;
        end else begin
            eff_len = CW'(i_key_length);
        end
    end

    always_comb begin
        win[0] = b;
        for (int i = 1; i < MAX_KEY_LENGTH; i++) begin
            win[i] = r_recent[i-1];
        end
    end

    // match for each candidate length, then pick the configured one
    always_comb begin
        hit = 1'b0;
        for (int m = 1; m <= MAX_KEY_LENGTH; m++) begin
            ok = 1'b1;
            for (int k = 0; k < m; k++) begin
                ok = ok && (win[m-1-k] == key_byte(i_key_chars, k));
            end
            hit = hit || (ok && (eff_len == CW'(m)));
        end
    end

    assign is_digit = b inside {[CHAR_0:CHAR_9]};
    assign digit    = 4'(b - CHAR_0);
    assign prod     = 35'({r_acc, 3'b000}) + 35'({r_acc, 1'b0}) + 35'(digit);

    always_comb begin
        n_recent = r_recent;
        n_bsc    = r_bsc;
        n_phase  = r_phase;
        n_neg    = r_neg;
        n_acc    = r_acc;
        n_found  = r_found;
        n_term   = r_term;
        n_over   = r_over;
        consumed = 1'b0;
        if (take) begin
            n_recent = win;
            n_term   = r_term || (b == CHAR_NUL);
            if (r_phase != PH_SEARCH) begin
                if (r_phase == PH_AFTER_KEY && b == CHAR_EQ) begin
                    n_phase  = PH_AFTER_EQ;
                    consumed = 1'b1;
                end else if ((r_phase == PH_AFTER_KEY || r_phase == PH_AFTER_EQ)
                             && b == CHAR_MINUS) begin
                    n_neg    = 1'b1;
                    n_phase  = PH_DIGITS;
                    consumed = 1'b1;
                end else if (is_digit) begin
                    consumed = 1'b1;
                    if (prod > 35'(ACC_MAX)) begin
                        n_over  = 1'b1;
                        n_acc   = '0;
                        n_phase = PH_SEARCH;
                        n_bsc   = '0;
                    end else begin
                        n_acc   = prod[30:0];
                        n_phase = PH_DIGITS;
                    end
                end else begin
                    n_phase = PH_SEARCH;
                    n_bsc   = '0;
                end
            end
            if (!consumed) begin
                if (n_bsc != MAX_LEN) begin
                    n_bsc = n_bsc + CW'(1);
                end
                if (!n_term && n_bsc >= eff_len && hit) begin
                    n_found = 1'b1;
                    n_acc   = '0;
                    n_neg   = 1'b0;
                    n_phase = PH_AFTER_KEY;
                    n_bsc   = '0;
                end
            end
        end

        n_res = r_res;
        if (res_now) begin
            if (!n_term) begin
                n_res.status = STATUS_NO_NUL;
            end else if (n_over) begin
                n_res.status = STATUS_OVERFLOW;
            end else begin
                n_res.status = STATUS_OK;
            end
            n_res.found = n_term && !n_over && n_found;
            if (n_res.found) begin
                n_res.value = n_neg ? $signed(32'd0 - {1'b0, n_acc}) : $signed({1'b0, n_acc});
            end else begin
                n_res.value = '0;
            end
            // text state starts over for the next text
            n_recent = '0;
            n_bsc    = '0;
            n_phase  = PH_SEARCH;
            n_neg    = 1'b0;
            n_acc    = '0;
            n_found  = 1'b0;
            n_term   = 1'b0;
            n_over   = 1'b0;
        end
        n_out_valid = res_now || (r_out_valid && !i_res_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recent    <= '0;
            r_bsc       <= '0;
            r_phase     <= PH_SEARCH;
            r_neg       <= 1'b0;
            r_acc       <= '0;
            r_found     <= 1'b0;
            r_term      <= 1'b0;
            r_over      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_recent    <= n_recent;
            r_bsc       <= n_bsc;
            r_phase     <= n_phase;
            r_neg       <= n_neg;
            r_acc       <= n_acc;
            r_found     <= n_found;
            r_term      <= n_term;
            r_over      <= n_over;
            r_out_valid <= n_out_valid;
        end
        r_res <= n_res;
    end

    `KDFE_ASSERT_NOW(a_fail_no_value, i_clk, i_rst_n, r_out_valid && r_res.status != STATUS_OK, !r_res.found && r_res.value == 32'sd0)
    `KDFE_ASSERT_NOW(a_value_in_range, i_clk, i_rst_n, r_out_valid && r_res.found, r_res.value != 32'sh8000_0000)
    `KDFE_ASSERT_NEXT(a_clear_after_last, i_clk, i_rst_n, res_now, r_phase == PH_SEARCH && !r_found && !r_term && !r_over)
    `KDFE_ASSERT_NOW(a_bsc_bound, i_clk, i_rst_n, 1'b1, r_bsc <= MAX_LEN)

endmodule

`default_nettype wire
